>>> rtl/ppsiea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PPS interval error accumulator package
// Shared widths, register indexes, reset values and interface types.
// ----------------------------------------------------------------------------
package ppsiea_pkg;

  localparam int CAPTURE_BITS = 16;
  localparam int OVF_W        = 16;
  localparam int WORD_W       = 32;
  localparam int CYC_W        = 31;
  localparam int LEN_W        = 7;
  localparam int CFG_IDX_W    = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_CYCLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_LEN   = 2'd2;

  localparam logic [CYC_W-1:0] NOMINAL_CYCLES_RST = 31'd10000000;
  localparam logic [CYC_W-1:0] ERROR_LIMIT_RST    = 31'd10000;
  localparam logic [LEN_W-1:0] INTERVAL_LEN_RST   = 7'd16;

  localparam logic [WORD_W-1:0] MOST_NEG_ERROR = 32'h8000_0000;

  typedef struct packed {
    logic [CYC_W-1:0] nominal_cycles;
    logic [CYC_W-1:0] error_limit;
    logic [LEN_W-1:0] interval_len;
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0]         report_count;
    logic signed [WORD_W-1:0] report_sum;
    logic                     report_ready;
    logic                     in_tolerance;
    logic signed [WORD_W-1:0] cycle_error;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/ppsiea_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PPS interval error accumulator configuration registers
// Holds nominal cycles, error limit and interval length from the write port.
// ----------------------------------------------------------------------------
module ppsiea_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ppsiea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ppsiea_pkg::CYC_W-1:0]   cfg_data,
  output ppsiea_pkg::cfg_t                    cfg
);
  import ppsiea_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nominal_cycles <= NOMINAL_CYCLES_RST;
      cfg.error_limit    <= ERROR_LIMIT_RST;
      cfg.interval_len   <= INTERVAL_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NOMINAL_CYCLES: cfg.nominal_cycles <= cfg_data;
        REG_ERROR_LIMIT:    cfg.error_limit    <= cfg_data;
        REG_INTERVAL_LEN:   cfg.interval_len   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/ppsiea_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PPS interval error accumulator core
// Input register, measurement state and the combinational error datapath.
// ----------------------------------------------------------------------------
module ppsiea_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ppsiea_pkg::cfg_t                  cfg,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_mode,
  input  wire logic [ppsiea_pkg::CAPTURE_BITS-1:0] in_capture,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output ppsiea_pkg::result_t                    res
);
  import ppsiea_pkg::*;

  logic                    item_valid;
  logic                    item_mode;
  logic [CAPTURE_BITS-1:0] item_capture;

  logic [OVF_W-1:0]        overflow_count;
  logic [CAPTURE_BITS-1:0] previous_capture;
  logic [WORD_W-1:0]       error_sum;
  logic [LEN_W-1:0]        second_count;

  logic              advance;
  logic [WORD_W-1:0] interval;
  logic [WORD_W-1:0] err;
  logic [WORD_W-1:0] mag;
  logic              ok;
  logic [WORD_W-1:0] error_sum_next;
  logic [LEN_W-1:0]  second_count_next;
  logic              ready;

  // a tick never waits on the output side
  assign advance   = item_valid && (!item_mode || res_ready);
  assign in_ready  = !item_valid || advance;
  assign res_valid = item_valid && item_mode;

  always_comb begin
    interval = (WORD_W'(overflow_count) << CAPTURE_BITS) + WORD_W'(item_capture)
               - WORD_W'(previous_capture);
    err  = interval - WORD_W'(cfg.nominal_cycles);
    mag  = err[WORD_W-1] ? (WORD_W'(0) - err) : err;
    ok   = (err != MOST_NEG_ERROR) && (mag <= WORD_W'(cfg.error_limit));
    error_sum_next    = error_sum + err;
    second_count_next = second_count + LEN_W'(1);
    ready = ok && (second_count_next >= cfg.interval_len);

    res.cycle_error  = err;
    res.in_tolerance = ok;
    res.report_ready = ready;
    res.report_sum   = ready ? error_sum_next : '0;
    res.report_count = ready ? second_count_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_mode    <= in_mode;
      item_capture <= in_capture;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_count   <= '0;
      previous_capture <= '0;
      error_sum        <= '0;
      second_count     <= '0;
    end else if (advance) begin
      if (!item_mode) begin
        overflow_count <= overflow_count + OVF_W'(1);
      end else begin
        overflow_count   <= '0;
        previous_capture <= item_capture;
        if (ok && !ready) begin
          error_sum    <= error_sum_next;
          second_count <= second_count_next;
        end else begin
          // drop the run on a report or an out-of-limit second
          error_sum    <= '0;
          second_count <= '0;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/ppsiea_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PPS interval error accumulator output register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module ppsiea_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          res_valid,
  output logic               res_ready,
  input  wire ppsiea_pkg::result_t res,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ppsiea_pkg::result_t out_res
);
  import ppsiea_pkg::*;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pps_interval_error_accumulator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PPS interval error accumulator
// Measures clock cycles between pps edges and accumulates the frequency error.
// ----------------------------------------------------------------------------
// Input beats: tuser = 0 is a 16-bit timer overflow tick, tuser = 1 is a pps
// capture with the latched timer value in tdata. Each capture produces one
// output beat with the cycle error, the tolerance flag and, when the interval
// of valid seconds completes, the report sum and count. Ticks produce nothing.
// Path: a beat is registered on entry, its result is worked out from the
// input register and lands in the output register when that register can
// take it; tvalid comes from the output register.
// Throughput: one beat per cycle unless a capture stalls; the subtracts, the
// magnitude compare and sum add lie between the input and output registers.
// Stall: while the output register holds an untaken result, the next capture
// waits in the input register and tready drops; ticks keep flowing behind it
// only after that capture moves on. Configuration writes take effect at once
// and belong to idle periods.
// Reset (rst, synchronous): clears both valid flags, the overflow counter,
// the previous capture, the sum and the count, and loads register defaults.
// ----------------------------------------------------------------------------
module pps_interval_error_accumulator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] capture_value
  input  wire logic        s_axis_tuser,   // [0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [31:0] cycle_error, [63:32] report_sum,
                                           // [70:64] report_count, [71] zero
  output logic [1:0]       m_axis_tuser    // [0] in_tolerance, [1] report_ready
);
  import ppsiea_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic    res_valid;
  logic    res_ready;

  ppsiea_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppsiea_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_mode    (s_axis_tuser),
    .in_capture (s_axis_tdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  ppsiea_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.report_count, out_res.report_sum,
                         out_res.cycle_error};
  assign m_axis_tuser = {out_res.report_ready, out_res.in_tolerance};

  // a report only closes a run of in-tolerance seconds
  a_report_in_tol : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("report flagged on an out-of-tolerance second");

  // report fields stay zero without a report
  a_report_zero : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |->
      (m_axis_tdata[63:32] == 32'd0) && (m_axis_tdata[70:64] == 7'd0))
    else $error("report fields nonzero without report_ready");

  // nothing comes out in the cycle after reset
  a_reset_empty : assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

>>> tb/pps_error_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPS interval error checker
// Follows the configuration writes and the accepted input beats, works out
// each second's error, tolerance and report on its own, and compares every
// result beat field by field against the oldest second still owed.
// ----------------------------------------------------------------------------
package pps_tb_pkg;

  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_CAPTURE = 1'b1;

endpackage

module pps_error_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] capture_value
  input  wire logic        s_axis_tuser,   // [0] mode
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [71:0] m_axis_tdata,   // [31:0] cycle_error, [63:32] report_sum,
                                           // [70:64] report_count, [71] zero
  input  wire logic [1:0]  m_axis_tuser,   // [0] in_tolerance, [1] report_ready
  output int               mismatches,
  output int               seconds_owed
);

  import ppsiea_pkg::*;
  import pps_tb_pkg::*;

  localparam int MAX_REPORTS = 40;

  cfg_t                    live_cfg;
  logic [OVF_W-1:0]        ovf_ticks;
  logic [CAPTURE_BITS-1:0] last_capture;
  logic [WORD_W-1:0]       error_total;
  logic [LEN_W-1:0]        good_seconds;
  result_t                 owed_seconds_q[$];
  int                      fail_count = 0;
  int                      owed_count = 0;

  assign mismatches   = fail_count;
  assign seconds_owed = owed_count;

  // One capture closes a second: measure it, judge it, fold it into the sum.
  function automatic result_t measure_second(input logic [CAPTURE_BITS-1:0] cap);
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] err;
    logic [WORD_W-1:0] mag;
    logic              ok;
    result_t           res;
    span = {ovf_ticks, {CAPTURE_BITS{1'b0}}} + WORD_W'(cap) - WORD_W'(last_capture);
    last_capture = cap;
    ovf_ticks = '0;
    err = span - WORD_W'(live_cfg.nominal_cycles);
    mag = err[WORD_W-1] ? -err : err;
    ok = (err != MOST_NEG_ERROR) && (mag <= WORD_W'(live_cfg.error_limit));
    res = '0;
    res.cycle_error  = err;
    res.in_tolerance = ok;
    if (ok) begin
      error_total  = error_total + err;
      good_seconds = good_seconds + 1'b1;
      if (good_seconds >= live_cfg.interval_len) begin
        res.report_ready = 1'b1;
        res.report_sum   = error_total;
        res.report_count = good_seconds;
        error_total  = '0;
        good_seconds = '0;
      end
    end else begin
      error_total  = '0;
      good_seconds = '0;
    end
    return res;
  endfunction

  function automatic void compare_field(input string fname, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $error("%s: expected %h, got %h", fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      live_cfg.nominal_cycles = NOMINAL_CYCLES_RST;
      live_cfg.error_limit    = ERROR_LIMIT_RST;
      live_cfg.interval_len   = INTERVAL_LEN_RST;
      ovf_ticks    = '0;
      last_capture = '0;
      error_total  = '0;
      good_seconds = '0;
      owed_seconds_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NOMINAL_CYCLES: live_cfg.nominal_cycles = cfg_data;
          REG_ERROR_LIMIT:    live_cfg.error_limit    = cfg_data;
          REG_INTERVAL_LEN:   live_cfg.interval_len   = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '0;
        got.cycle_error  = m_axis_tdata[31:0];
        got.report_sum   = m_axis_tdata[63:32];
        got.report_count = m_axis_tdata[70:64];
        got.in_tolerance = m_axis_tuser[0];
        got.report_ready = m_axis_tuser[1];
        if (owed_seconds_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("result beat with no capture outstanding: tdata %h tuser %h",
                   m_axis_tdata, m_axis_tuser);
        end else begin
          want = owed_seconds_q.pop_front();
          compare_field("cycle_error",  want.cycle_error,  got.cycle_error);
          compare_field("in_tolerance", WORD_W'(want.in_tolerance),
                        WORD_W'(got.in_tolerance));
          compare_field("report_ready", WORD_W'(want.report_ready),
                        WORD_W'(got.report_ready));
          compare_field("report_sum",   want.report_sum,   got.report_sum);
          compare_field("report_count", WORD_W'(want.report_count),
                        WORD_W'(got.report_count));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == MODE_CAPTURE)
          owed_seconds_q.push_back(measure_second(s_axis_tdata[CAPTURE_BITS-1:0]));
        else
          ovf_ticks = ovf_ticks + 1'b1;
      end
    end
    owed_count <= owed_seconds_q.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPS interval error accumulator testbench
// Feeds timer ticks and pps captures shaped into seconds near the nominal
// count, under several register settings, with random input gaps and result
// back-pressure; the checker beside the block judges every result beat.
// ----------------------------------------------------------------------------
module testbench;

  import ppsiea_pkg::*;
  import pps_tb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_we        = 1'b0;
  logic [1:0]  cfg_index     = REG_NOMINAL_CYCLES;
  logic [30:0] cfg_data      = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = MODE_TICK;
  logic        m_axis_tready = 1'b0;
  wire logic        s_axis_tready;
  wire logic        m_axis_tvalid;
  wire logic [71:0] m_axis_tdata;
  wire logic [1:0]  m_axis_tuser;

  int          mismatches;
  int          seconds_owed;
  int          beats_sent   = 0;
  int          stall_cycles = 0;
  int          hold_left    = 0;
  bit          no_gaps      = 1'b0;
  bit          hold_request = 1'b0;
  logic [15:0] sent_prev    = '0;
  logic [30:0] cur_nominal  = NOMINAL_CYCLES_RST;
  logic [30:0] cur_limit    = ERROR_LIMIT_RST;

  pps_interval_error_accumulator_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  pps_error_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .seconds_owed  (seconds_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random back-pressure, plus one long hold when asked.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (no_gaps) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 28);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** pps_interval_error_accumulator_top: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_beat(input logic mode, input logic [15:0] value);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    beats_sent++;
    if (mode == MODE_CAPTURE)
      sent_prev = value;
    while (!no_gaps && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tuser  <= 1'($urandom);
      s_axis_tdata  <= 16'($urandom);
      @(posedge clk);
    end
  endtask

  // Hold input, let every owed result land, then cover the pipeline latency.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (seconds_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [30:0] nom, input logic [30:0] lim,
                               input logic [6:0] len);
    write_reg(REG_NOMINAL_CYCLES, nom);
    write_reg(REG_ERROR_LIMIT, lim);
    write_reg(REG_INTERVAL_LEN, 31'(len));
    cur_nominal = nom;
    cur_limit   = lim;
  endtask

  // Mostly near the limit window, some right on its edge, some beyond it.
  function automatic longint pick_offset();
    longint lim;
    longint reach;
    int     roll;
    lim  = longint'(cur_limit);
    roll = $urandom_range(99);
    if (roll < 70) begin
      reach = (lim > 3000) ? 3000 : lim;
      return longint'($urandom_range(0, 32'(2 * reach))) - reach;
    end else if (roll < 85) begin
      return $urandom_range(1) ? lim : -lim;
    end
    reach = lim + 1 + longint'($urandom_range(0, 5000));
    return $urandom_range(1) ? reach : -reach;
  endfunction

  // Send a second of this error as ticks and a capture, or a random capture.
  task automatic send_second(input longint offset);
    logic [31:0] span;
    logic [47:0] target;
    int unsigned ticks;
    span   = 32'(longint'(cur_nominal) + offset);
    target = 48'(sent_prev) + 48'(span);
    ticks  = target[47:16];
    if (span[31] || ticks > 24) begin
      send_beat(MODE_CAPTURE, 16'($urandom));
    end else begin
      repeat (ticks) send_beat(MODE_TICK, 16'($urandom));
      send_beat(MODE_CAPTURE, target[15:0]);
    end
  endtask

  task automatic run_phase(input int count);
    int stop_at;
    int roll;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 80)
        send_second(pick_offset());
      else if (roll < 90)
        send_beat(MODE_TICK, 16'($urandom));
      else
        send_beat(MODE_CAPTURE, 16'($urandom));
    end
  endtask

  task automatic choose_setting(input int phase);
    logic [30:0] nom;
    logic [30:0] lim;
    logic [6:0]  len;
    nom = ($urandom_range(9) == 0) ? 31'd1 : 31'($urandom_range(1, 200000));
    case ($urandom_range(3))
      0:       lim = '0;
      1:       lim = 31'($urandom_range(0, 100));
      2:       lim = 31'($urandom_range(0, 5000));
      default: lim = 31'h7FFF_FFFF;
    endcase
    case ($urandom_range(4))
      0:       len = 7'd0;
      1:       len = 7'd1;
      2:       len = 7'($urandom_range(2, 16));
      3:       len = 7'($urandom_range(17, 127));
      default: len = 7'($urandom_range(2, 8));
    endcase
    if (phase == 0) begin
      lim = 31'h7FFF_FFFF;
      len = 7'd127;
    end
    apply_setting(nom, lim, len);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: a tick carrying a value to ignore, then a capture below
    // the previous one so the interval wraps.
    send_beat(MODE_TICK, 16'hFFFF);
    send_beat(MODE_CAPTURE, 16'hFFFF);
    send_beat(MODE_CAPTURE, 16'h0000);
    settle();
    // Zero nominal, widest limit, zero length: every good second reports alone.
    apply_setting(31'd0, 31'h7FFF_FFFF, 7'd0);
    send_beat(MODE_CAPTURE, 16'h0000);
    send_beat(MODE_CAPTURE, 16'h1234);
    settle();
    // Interval of all ones against the largest nominal: most negative error.
    // Then zero intervals, each just inside the limit, so the sum wraps.
    apply_setting(31'h7FFF_FFFF, 31'h7FFF_FFFF, 7'd127);
    send_beat(MODE_CAPTURE, 16'h1233);
    repeat (3) send_beat(MODE_CAPTURE, 16'h1233);
    settle();
    // Length drops under the running count: the next good second reports.
    apply_setting(31'h7FFF_FFFF, 31'h7FFF_FFFF, 7'd2);
    send_beat(MODE_CAPTURE, 16'h1233);
    settle();
    // Zero limit: only an exact second passes.
    apply_setting(31'd65536, 31'd0, 7'd1);
    send_beat(MODE_TICK, 16'h0000);
    send_beat(MODE_CAPTURE, 16'h1233);
    send_beat(MODE_CAPTURE, 16'h1233);
    send_beat(MODE_TICK, 16'h5A5A);
    send_beat(MODE_CAPTURE, 16'h1234);

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      choose_setting(phase);
      no_gaps = (phase == 1);
      if (phase == 2)
        hold_request = 1'b1;
      if (phase == 0) begin
        run_phase(160);
      end else if (phase == 3) begin
        run_phase(45);
        settle();
        run_phase(45);
      end else begin
        run_phase(90);
      end
    end
    no_gaps = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("** pps_interval_error_accumulator_top: PASSED **");
    else
      $display("** pps_interval_error_accumulator_top: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
rtl/ppsiea_pkg.sv
rtl/ppsiea_cfg.sv
rtl/ppsiea_core.sv
rtl/ppsiea_out_reg.sv
rtl/pps_interval_error_accumulator_top.sv
tb/pps_error_checker.sv
tb/testbench.sv
